// ----- design/fjam_pkg.sv -----
`timescale 1ns / 1ps
package fjam_pkg;

    localparam int ID_W        = 6;
    localparam int FLOW_IDS    = 1 << ID_W;
    localparam int FLOWS_DEF   = 64;
    localparam int TIME_W      = 32;
    localparam int CNT_W       = 16;
    localparam int GAP_W       = 33;
    localparam int GAP_WIDE_W  = 35;
    localparam int MS_W        = 49;
    localparam int DIV_W       = 50;
    localparam int DVS_W       = 16;
    localparam int TH_W        = 52;
    localparam int TOT_W       = 7;
    localparam int ALERT_TOT_W = 32;
    localparam int S_DATA_W    = 40;
    localparam int M_DATA_W    = 120;

    localparam int DIV_ITER_W      = 5;
    localparam int DIV_SHORT_SHIFT = DIV_W - TIME_W;

    localparam logic [DIV_ITER_W-1:0] DIV_SHORT_ITER = DIV_ITER_W'(TIME_W / 2);
    localparam logic [DIV_ITER_W-1:0] DIV_LONG_ITER  = DIV_ITER_W'(DIV_W / 2);

    localparam logic [CNT_W-1:0]       CNT_MAX        = '1;
    localparam logic [CNT_W-1:0]       CNT_MIN_OLD    = CNT_W'(2);
    localparam logic [CNT_W-1:0]       ANOM_MIN_COUNT = CNT_W'(4);
    localparam logic [TOT_W-1:0]       TOT_MAX        = '1;
    localparam logic [ALERT_TOT_W-1:0] ALERT_TOT_MAX  = '1;

    localparam logic signed [GAP_WIDE_W-1:0] GAP_SUM_MAX = 35'sd4294967295;
    localparam logic signed [GAP_WIDE_W-1:0] GAP_SUM_MIN = -35'sd4294967295;
    localparam logic signed [DIV_W-1:0]      MS_MAX      = 50'sd281474976710655;
    localparam logic signed [DIV_W-1:0]      MS_MIN      = -50'sd281474976710656;

    typedef struct packed {
        logic [TIME_W-1:0]       last_arrival;
        logic [CNT_W-1:0]        pkt_count;
        logic signed [GAP_W-1:0] gap_sum;
        logic signed [MS_W-1:0]  mean_sum;
        logic                    flagged;
        logic [CNT_W-1:0]        alert_count;
    } entry_t;

endpackage

// ----- design/fjam_div.sv -----
`timescale 1ns / 1ps
module fjam_div (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  short_run,
    input  logic signed [fjam_pkg::DIV_W-1:0]     dividend,
    input  logic [fjam_pkg::DVS_W-1:0]            divisor,
    output logic                                  done,
    output logic signed [fjam_pkg::DIV_W-1:0]     quotient
);

    logic                                busy_reg;
    logic                                fin_reg;
    logic                                done_reg;
    logic [fjam_pkg::DIV_ITER_W-1:0]     cnt_reg;
    logic                                neg_reg;
    logic [fjam_pkg::DVS_W-1:0]          rem_reg;
    logic [fjam_pkg::DIV_W-1:0]          quo_reg;
    logic signed [fjam_pkg::DIV_W-1:0]   quotient_reg;

    logic [fjam_pkg::DIV_W-1:0]          mag;
    logic [fjam_pkg::DVS_W:0]            r1;
    logic [fjam_pkg::DVS_W:0]            r2;
    logic [fjam_pkg::DVS_W:0]            dv;
    logic                                ge1;
    logic                                ge2;
    logic [fjam_pkg::DVS_W-1:0]          rem1;
    logic [fjam_pkg::DVS_W-1:0]          rem2;
    logic [fjam_pkg::DIV_W-1:0]          quo_next;

    assign mag = dividend[fjam_pkg::DIV_W-1] ? fjam_pkg::DIV_W'(-dividend)
                                             : fjam_pkg::DIV_W'(dividend);
    assign dv  = {1'b0, divisor};

    always_comb
    begin
        r1       = {rem_reg, quo_reg[fjam_pkg::DIV_W-1]};
        ge1      = (r1 >= dv);
        rem1     = ge1 ? fjam_pkg::DVS_W'(r1 - dv) : r1[fjam_pkg::DVS_W-1:0];
        r2       = {rem1, quo_reg[fjam_pkg::DIV_W-2]};
        ge2      = (r2 >= dv);
        rem2     = ge2 ? fjam_pkg::DVS_W'(r2 - dv) : r2[fjam_pkg::DVS_W-1:0];
        quo_next = {quo_reg[fjam_pkg::DIV_W-3:0], ge1, ge2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= short_run ? fjam_pkg::DIV_SHORT_ITER : fjam_pkg::DIV_LONG_ITER;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - fjam_pkg::DIV_ITER_W'(1);
                if (cnt_reg == fjam_pkg::DIV_ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[fjam_pkg::DIV_W-1];
            rem_reg <= '0;
            quo_reg <= short_run ? (mag << fjam_pkg::DIV_SHORT_SHIFT) : mag;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem2;
            quo_reg <= quo_next;
        end
        if (fin_reg)
        begin
            quotient_reg <= neg_reg ? $signed(-quo_reg) : $signed(quo_reg);
        end
    end

    assign done     = done_reg;
    assign quotient = quotient_reg;

endmodule

// ----- design/fjam_store.sv -----
`timescale 1ns / 1ps
module fjam_store #(
    parameter int DEPTH = fjam_pkg::FLOWS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output fjam_pkg::entry_t           rd_entry,
    output logic                       rd_valid,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  fjam_pkg::entry_t           wr_entry
);

    fjam_pkg::entry_t mem [DEPTH];
    fjam_pkg::entry_t rd_entry_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;
    assign rd_valid = rd_valid_reg;

endmodule

// ----- design/flow_jitter_anomaly_monitor.sv -----
`timescale 1ns / 1ps
// channel   | handshake                   | tdata (low bit up)
// s_axis    | s_axis_tvalid/s_axis_tready | flow_id[5:0], arrival_time[37:6]
// m_axis    | m_axis_tvalid/m_axis_tready | new_flow, mean_gap .. total_alerts (see port)
//
// A packet of a known flow passes READ, GAP, DG0, DGW, DM0, DMW, TH1, TH2, CMP and OUT;
// a packet that opens a flow goes from READ straight to OUT. The shared radix-4 divider
// gives the gap sum quotient and then the mean sum quotient, one after the other.
// s_axis_tready is high only while the sequencer is idle; one finished result may wait
// in the output register while the next packet is accepted.
// Reset clears the valid bits, the totals and the sequencer; no clearing pass is needed.
module flow_jitter_anomaly_monitor #(
    parameter int FLOWS = fjam_pkg::FLOWS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // flow_id[5:0], arrival_time[37:6], zero[39:38]
    input  logic [fjam_pkg::S_DATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // new_flow[0], mean_gap[33:1], anomaly[34], first_anomaly[35], packet_count[51:36],
    // flow_alert_count[67:52], active_flows[74:68], anomalous_flows[81:75],
    // total_alerts[113:82], zero[119:114]
    output logic [fjam_pkg::M_DATA_W-1:0]  m_axis_tdata
);

    localparam int NENT  = (FLOWS < fjam_pkg::FLOW_IDS) ? FLOWS : fjam_pkg::FLOW_IDS;
    localparam int IDX_W = $clog2(NENT);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_READ = 4'd1;
    localparam logic [3:0] S_GAP  = 4'd2;
    localparam logic [3:0] S_DG0  = 4'd3;
    localparam logic [3:0] S_DGW  = 4'd4;
    localparam logic [3:0] S_DM0  = 4'd5;
    localparam logic [3:0] S_DMW  = 4'd6;
    localparam logic [3:0] S_TH1  = 4'd7;
    localparam logic [3:0] S_TH2  = 4'd8;
    localparam logic [3:0] S_CMP  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    logic [IDX_W-1:0] idx_map [fjam_pkg::FLOW_IDS];

    for (genvar g = 0; g < fjam_pkg::FLOW_IDS; g++)
    begin : g_idx
        assign idx_map[g] = IDX_W'(g % FLOWS);
    end

    logic                                    s_acc;
    logic                                    out_free;
    logic [fjam_pkg::ID_W-1:0]               in_flow;
    logic [fjam_pkg::TIME_W-1:0]             in_time;

    logic [IDX_W-1:0]                        idx_reg;
    logic [fjam_pkg::TIME_W-1:0]             t_reg;
    logic [fjam_pkg::CNT_W-1:0]              cnt_n_reg;
    logic signed [fjam_pkg::GAP_W-1:0]       delta_reg;
    logic signed [fjam_pkg::GAP_W-1:0]       gsum_reg;
    logic [fjam_pkg::DVS_W-1:0]              div_reg;
    logic signed [fjam_pkg::GAP_W-1:0]       mg_reg;
    logic signed [fjam_pkg::DIV_W-1:0]       avg_reg;
    logic signed [fjam_pkg::TH_W-1:0]        t3_reg;
    logic signed [fjam_pkg::TH_W-1:0]        lo_reg;
    logic signed [fjam_pkg::TH_W-1:0]        hi_reg;
    logic signed [fjam_pkg::MS_W-1:0]        msum_reg;
    logic                                    new_reg;
    logic                                    anom_reg;
    logic                                    first_reg;
    fjam_pkg::entry_t                        wr_reg;
    logic [fjam_pkg::TOT_W-1:0]              act_reg;
    logic [fjam_pkg::TOT_W-1:0]              flg_reg;
    logic [fjam_pkg::ALERT_TOT_W-1:0]        alr_reg;
    logic                                    m_tvalid_reg;
    logic [fjam_pkg::M_DATA_W-1:0]           m_tdata_reg;

    fjam_pkg::entry_t                        rd_entry;
    logic                                    rd_valid;
    logic                                    div_start;
    logic                                    div_done;
    logic signed [fjam_pkg::DIV_W-1:0]       div_dividend;
    logic signed [fjam_pkg::DIV_W-1:0]       div_q;

    logic [fjam_pkg::CNT_W-1:0]              cnt_inc;
    logic [fjam_pkg::CNT_W-1:0]              cnt_n;
    logic signed [fjam_pkg::GAP_W-1:0]       delta;
    logic signed [fjam_pkg::GAP_WIDE_W-1:0]  gs_wide;
    logic signed [fjam_pkg::DIV_W-1:0]       ms_wide;
    logic signed [fjam_pkg::TH_W-1:0]        avg_x;
    logic signed [fjam_pkg::TH_W-1:0]        mg_x;
    logic                                    anom;
    logic [fjam_pkg::CNT_W-1:0]              alert_inc;
    logic [fjam_pkg::TOT_W-1:0]              act_next;
    logic [fjam_pkg::TOT_W-1:0]              flg_next;
    logic [fjam_pkg::ALERT_TOT_W-1:0]        alr_next;

    assign in_flow  = s_axis_tdata[fjam_pkg::ID_W-1:0];
    assign in_time  = s_axis_tdata[fjam_pkg::ID_W +: fjam_pkg::TIME_W];
    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_tvalid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    fjam_store #(
        .DEPTH (NENT)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (s_acc),
        .rd_addr  (idx_map[in_flow]),
        .rd_entry (rd_entry),
        .rd_valid (rd_valid),
        .wr_en    ((state_reg == S_OUT) && out_free),
        .wr_addr  (idx_reg),
        .wr_entry (wr_reg)
    );

    assign div_start    = (state_reg == S_DG0) || (state_reg == S_DM0);
    assign div_dividend = (state_reg == S_DG0) ? fjam_pkg::DIV_W'(gsum_reg)
                                               : fjam_pkg::DIV_W'(rd_entry.mean_sum);

    fjam_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .short_run (state_reg == S_DG0),
        .dividend  (div_dividend),
        .divisor   (div_reg),
        .done      (div_done),
        .quotient  (div_q)
    );

    always_comb
    begin
        cnt_inc = (rd_entry.pkt_count == fjam_pkg::CNT_MAX) ? rd_entry.pkt_count
                : rd_entry.pkt_count + fjam_pkg::CNT_W'(1);
        cnt_n   = (cnt_inc < fjam_pkg::CNT_MIN_OLD) ? fjam_pkg::CNT_MIN_OLD : cnt_inc;
        delta   = $signed({1'b0, t_reg}) - $signed({1'b0, rd_entry.last_arrival});
        gs_wide = fjam_pkg::GAP_WIDE_W'(rd_entry.gap_sum)
                + fjam_pkg::GAP_WIDE_W'(delta_reg);
        ms_wide = fjam_pkg::DIV_W'(rd_entry.mean_sum) + fjam_pkg::DIV_W'(mg_reg);
        avg_x   = fjam_pkg::TH_W'(avg_reg);
        mg_x    = fjam_pkg::TH_W'(mg_reg);
        anom    = ((mg_x > hi_reg) || (mg_x < lo_reg))
                && (cnt_n_reg > fjam_pkg::ANOM_MIN_COUNT);
        alert_inc = (rd_entry.alert_count == fjam_pkg::CNT_MAX) ? rd_entry.alert_count
                  : rd_entry.alert_count + fjam_pkg::CNT_W'(1);
        act_next = (new_reg && act_reg != fjam_pkg::TOT_MAX)
                 ? act_reg + fjam_pkg::TOT_W'(1) : act_reg;
        flg_next = (first_reg && flg_reg != fjam_pkg::TOT_MAX)
                 ? flg_reg + fjam_pkg::TOT_W'(1) : flg_reg;
        alr_next = (anom_reg && alr_reg != fjam_pkg::ALERT_TOT_MAX)
                 ? alr_reg + fjam_pkg::ALERT_TOT_W'(1) : alr_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_acc) state_next = S_READ;
            S_READ: state_next = rd_valid ? S_GAP : S_OUT;
            S_GAP:  state_next = S_DG0;
            S_DG0:  state_next = S_DGW;
            S_DGW:  if (div_done) state_next = S_DM0;
            S_DM0:  state_next = S_DMW;
            S_DMW:  if (div_done) state_next = S_TH1;
            S_TH1:  state_next = S_TH2;
            S_TH2:  state_next = S_CMP;
            S_CMP:  state_next = S_OUT;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            act_reg      <= '0;
            flg_reg      <= '0;
            alr_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_OUT) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
                act_reg      <= act_next;
                flg_reg      <= flg_next;
                alr_reg      <= alr_next;
            end
            else if (m_axis_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                idx_reg <= idx_map[in_flow];
                t_reg   <= in_time;
            end
            S_READ:
            begin
                cnt_n_reg <= cnt_n;
                delta_reg <= delta;
                new_reg   <= !rd_valid;
                anom_reg  <= 1'b0;
                first_reg <= 1'b0;
                mg_reg    <= '0;
                wr_reg.last_arrival <= t_reg;
                wr_reg.pkt_count    <= fjam_pkg::CNT_W'(1);
                wr_reg.gap_sum      <= '0;
                wr_reg.mean_sum     <= '0;
                wr_reg.flagged      <= 1'b0;
                wr_reg.alert_count  <= '0;
            end
            S_GAP:
            begin
                if (gs_wide > fjam_pkg::GAP_SUM_MAX)
                begin
                    gsum_reg <= fjam_pkg::GAP_SUM_MAX[fjam_pkg::GAP_W-1:0];
                end
                else if (gs_wide < fjam_pkg::GAP_SUM_MIN)
                begin
                    gsum_reg <= fjam_pkg::GAP_SUM_MIN[fjam_pkg::GAP_W-1:0];
                end
                else
                begin
                    gsum_reg <= gs_wide[fjam_pkg::GAP_W-1:0];
                end
                div_reg <= cnt_n_reg - fjam_pkg::CNT_W'(1);
            end
            S_DGW:
            begin
                if (div_done)
                begin
                    mg_reg <= div_q[fjam_pkg::GAP_W-1:0];
                end
            end
            S_DMW:
            begin
                if (div_done)
                begin
                    avg_reg <= div_q;
                end
            end
            S_TH1:
            begin
                t3_reg <= (avg_x <<< 1) + avg_x;
                lo_reg <= (avg_x + $signed({{(fjam_pkg::TH_W-1){1'b0}},
                                             avg_x[fjam_pkg::TH_W-1]})) >>> 1;
            end
            S_TH2:
            begin
                hi_reg <= (t3_reg + $signed({{(fjam_pkg::TH_W-1){1'b0}},
                                              t3_reg[fjam_pkg::TH_W-1]})) >>> 1;
                if (ms_wide > fjam_pkg::MS_MAX)
                begin
                    msum_reg <= fjam_pkg::MS_MAX[fjam_pkg::MS_W-1:0];
                end
                else if (ms_wide < fjam_pkg::MS_MIN)
                begin
                    msum_reg <= fjam_pkg::MS_MIN[fjam_pkg::MS_W-1:0];
                end
                else
                begin
                    msum_reg <= ms_wide[fjam_pkg::MS_W-1:0];
                end
            end
            S_CMP:
            begin
                anom_reg  <= anom;
                first_reg <= anom && !rd_entry.flagged;
                wr_reg.last_arrival <= t_reg;
                wr_reg.pkt_count    <= cnt_n_reg;
                wr_reg.gap_sum      <= gsum_reg;
                wr_reg.mean_sum     <= msum_reg;
                wr_reg.flagged      <= rd_entry.flagged || anom;
                if (!anom)
                begin
                    wr_reg.alert_count <= rd_entry.alert_count;
                end
                else if (!rd_entry.flagged)
                begin
                    wr_reg.alert_count <= fjam_pkg::CNT_W'(1);
                end
                else
                begin
                    wr_reg.alert_count <= alert_inc;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    m_tdata_reg <= {6'b0, alr_next, flg_next, act_next,
                                    wr_reg.alert_count, wr_reg.pkt_count,
                                    first_reg, anom_reg, mg_reg, new_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- design/fjam_checker.sv -----
`timescale 1ns / 1ps
module fjam_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [fjam_pkg::M_DATA_W-1:0]  m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready after transaction");

    a_new_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |->
        (m_axis_tdata[33:1] == '0 && !m_axis_tdata[34] && !m_axis_tdata[35]
         && m_axis_tdata[51:36] == 16'd1))
        else $error("new flow result malformed");

    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[35]) |->
        (m_axis_tdata[34] && m_axis_tdata[67:52] == 16'd1 && m_axis_tdata[81:75] != '0))
        else $error("first anomaly inconsistent");

    a_anomaly: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[34]) |->
        (m_axis_tdata[51:36] > fjam_pkg::ANOM_MIN_COUNT && m_axis_tdata[113:82] != '0))
        else $error("anomaly without count or total");

endmodule

bind flow_jitter_anomaly_monitor fjam_checker u_fjam_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
